// ----- rtl/core/cse_pkg.sv -----
// ----------------------------------------------------------------------------
// cse_pkg: shared types and constants of the cubic spline evaluator
// Item and result layouts, function codes and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int MAX_KNOTS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_VALUE = 2'd1;
  localparam logic [1:0] FUNC_DERIV = 2'd2;

  localparam logic [6:0] KNOT_COUNT_MIN = 7'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         entry_index;
    logic signed [31:0] knot_value;
    logic signed [31:0] coef_const;
    logic signed [31:0] coef_lin;
    logic signed [31:0] coef_quad;
    logic signed [31:0] coef_cubic;
    logic signed [31:0] query_x;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               out_of_range;
    logic [5:0]         segment;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic       accept;    // item taken this cycle
    logic       out_zero;  // result for a load or unused code
    logic       out_oor;   // result for a query with no segment
    logic       out_val;   // result from the evaluation register
    logic       prev_ld;   // keep current knot as the lower knot
    logic       p_ld;      // form p from the lower knot
    logic       coef_rd;   // read the coefficients of the segment
    logic       t_init;    // load the Horner accumulator
    logic       mul;       // register t * p
    logic       acc;       // add the coefficient of this step
    logic       deriv;     // slope rather than value
    logic [1:0] step;      // Horner step
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic le;       // query <= knot just read
    logic ge;       // query >= knot just read
    logic prev_ge;  // query >= lower knot of the segment under test
  } sts_t;

endpackage

// ----- rtl/core/cse_ctrl.sv -----
// ----------------------------------------------------------------------------
// cse_ctrl: controller of the cubic spline evaluator
// Holds the knot count register, walks the knot table and sequences the
// Horner steps of the datapath.
// ----------------------------------------------------------------------------
module cse_ctrl import cse_pkg::*; #(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF,
  localparam int AW = $clog2(MAX_KNOTS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    func,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_data,
  input  sts_t          sts,
  output logic          busy,
  output cmd_t          cmd,
  output logic [AW-1:0] knot_addr,
  output logic [AW-1:0] seg_idx
);

  localparam int NW = $clog2(MAX_KNOTS + 1);
  localparam int CW = (NW > 7) ? NW : 7;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_RD_LAST = 8'b0000_0010,
    S_SCAN0   = 8'b0000_0100,
    S_SCAN    = 8'b0000_1000,
    S_EV_LOAD = 8'b0001_0000,
    S_MUL     = 8'b0010_0000,
    S_ACC     = 8'b0100_0000,
    S_FINISH  = 8'b1000_0000
  } state_t;

  state_t        state, state_next;
  logic [6:0]    knot_count;
  logic [AW-1:0] last_idx, last_idx_next;
  logic [AW-1:0] idx, idx_next;
  logic [1:0]    step, step_next;
  logic          deriv, deriv_next;
  logic          hi_ok, hi_ok_next;
  logic [CW-1:0] count_ext;
  logic [CW-1:0] n_clamp;
  logic          is_eval;

  assign count_ext = CW'(knot_count);
  assign is_eval   = (func == FUNC_VALUE) || (func == FUNC_DERIV);

  always_comb begin
    if (count_ext < CW'(KNOT_COUNT_MIN)) begin
      n_clamp = CW'(KNOT_COUNT_MIN);
    end else if (count_ext > CW'(MAX_KNOTS)) begin
      n_clamp = CW'(MAX_KNOTS);
    end else begin
      n_clamp = count_ext;
    end
  end

  assign last_idx_next = AW'(n_clamp - CW'(1));

  always_comb begin
    state_next = state;
    idx_next   = idx;
    step_next  = step;
    deriv_next = deriv;
    hi_ok_next = hi_ok;
    knot_addr  = '0;
    cmd        = '0;
    cmd.deriv  = deriv;
    cmd.step   = step;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (is_eval) begin
            knot_addr  = last_idx_next;
            deriv_next = (func == FUNC_DERIV);
            state_next = S_RD_LAST;
          end else begin
            cmd.out_zero = 1'b1;
          end
        end
      end
      S_RD_LAST: begin
        hi_ok_next = sts.le;
        knot_addr  = '0;
        state_next = S_SCAN0;
      end
      S_SCAN0: begin
        cmd.prev_ld = 1'b1;
        if (!(hi_ok && sts.ge)) begin
          cmd.out_oor = 1'b1;
          state_next  = S_IDLE;
        end else begin
          idx_next   = '0;
          knot_addr  = AW'(1);
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.prev_ge && sts.le) begin
          cmd.p_ld    = 1'b1;
          cmd.coef_rd = 1'b1;
          state_next  = S_EV_LOAD;
        end else if (idx + AW'(1) == last_idx) begin
          cmd.out_oor = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.prev_ld = 1'b1;
          idx_next    = idx + AW'(1);
          knot_addr   = idx + AW'(2);
        end
      end
      S_EV_LOAD: begin
        cmd.t_init = 1'b1;
        step_next  = 2'd0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (step == (deriv ? 2'd1 : 2'd2)) begin
          state_next = S_FINISH;
        end else begin
          step_next  = step + 2'd1;
          state_next = S_MUL;
        end
      end
      S_FINISH: begin
        cmd.out_val = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      knot_count <= KNOT_COUNT_MIN;
      last_idx   <= AW'(2);
      idx        <= '0;
      step       <= '0;
      deriv      <= 1'b0;
      hi_ok      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        knot_count <= cfg_data;
      end
      if (cmd.accept) begin
        last_idx <= last_idx_next;
      end
      idx   <= idx_next;
      step  <= step_next;
      deriv <= deriv_next;
      hi_ok <= hi_ok_next;
    end
  end

  assign busy    = (state != S_IDLE);
  assign seg_idx = idx;

  a_eval_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && is_eval) |=> (state == S_RD_LAST))
    else $error("evaluation did not start with the range read");

  a_scan_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (idx < last_idx))
    else $error("segment scan ran past the last knot");

  a_enough_knots: assert property (@(posedge clk) disable iff (rst)
    busy |-> (last_idx >= AW'(2)))
    else $error("fewer than three knots in use");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> (deriv ? (step <= 2'd1) : (step <= 2'd2)))
    else $error("Horner step out of range");

endmodule

// ----- rtl/core/cse_dp.sv -----
// ----------------------------------------------------------------------------
// cse_dp: datapath of the cubic spline evaluator
// Knot and coefficient memories, range compares, the shared multiplier of
// the Horner evaluation and the result register.
// ----------------------------------------------------------------------------
module cse_dp import cse_pkg::*; #(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int AW = $clog2(MAX_KNOTS)
) (
  input  logic          clk,
  input  logic          rst,
  input  in_t           item,
  input  cmd_t          cmd,
  input  logic [AW-1:0] knot_addr,
  input  logic [AW-1:0] seg_idx,
  output sts_t          sts,
  output logic          done,
  output out_t          result
);

  logic signed [31:0] knot_mem  [MAX_KNOTS];
  logic signed [31:0] const_mem [MAX_KNOTS];
  logic signed [31:0] lin_mem   [MAX_KNOTS];
  logic signed [31:0] quad_mem  [MAX_KNOTS];
  logic signed [31:0] cubic_mem [MAX_KNOTS];

  logic signed [31:0] knot_rdata;
  logic signed [31:0] c_const, c_lin, c_quad, c_cubic;
  logic signed [31:0] q;
  logic signed [31:0] prev_knot;
  logic               prev_ge;
  logic signed [32:0] p;
  logic signed [31:0] t;
  logic signed [64:0] prod;
  logic signed [64:0] prod_sh;
  logic signed [33:0] addend;
  logic signed [65:0] sum;
  logic signed [65:0] cubic_ext;
  logic signed [65:0] cubic_x3;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if ((&v[65:31]) || !(|v[65:31])) begin
      r = v[31:0];
    end else if (v[65]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  assign wr_en   = cmd.accept && (item.func == FUNC_LOAD) &&
                   (32'(item.entry_index) < 32'(MAX_KNOTS));
  assign wr_addr = AW'(item.entry_index);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      knot_mem[wr_addr]  <= item.knot_value;
      const_mem[wr_addr] <= item.coef_const;
      lin_mem[wr_addr]   <= item.coef_lin;
      quad_mem[wr_addr]  <= item.coef_quad;
      cubic_mem[wr_addr] <= item.coef_cubic;
    end
    knot_rdata <= knot_mem[knot_addr];
    if (cmd.coef_rd) begin
      c_const <= const_mem[seg_idx];
      c_lin   <= lin_mem[seg_idx];
      c_quad  <= quad_mem[seg_idx];
      c_cubic <= cubic_mem[seg_idx];
    end
  end

  assign sts.le      = (q <= knot_rdata);
  assign sts.ge      = (q >= knot_rdata);
  assign sts.prev_ge = prev_ge;

  // The slope starts from 3d, saturated; the value starts from d.
  assign cubic_ext = {{34{c_cubic[31]}}, c_cubic};
  assign cubic_x3  = cubic_ext + (cubic_ext <<< 1);

  always_comb begin
    case (cmd.step)
      2'd0:    addend = cmd.deriv ? {c_quad[31], c_quad, 1'b0}
                                  : {{2{c_quad[31]}}, c_quad};
      2'd1:    addend = {{2{c_lin[31]}}, c_lin};
      default: addend = {{2{c_const[31]}}, c_const};
    endcase
  end

  // Arithmetic shift floors the product, as the truncation requires.
  assign prod_sh = prod >>> FRAC_BITS;
  assign sum     = {prod_sh[64], prod_sh} + {{32{addend[33]}}, addend};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q <= item.query_x;
    end
    if (cmd.prev_ld) begin
      prev_knot <= knot_rdata;
      prev_ge   <= sts.ge;
    end
    if (cmd.p_ld) begin
      p <= {q[31], q} - {prev_knot[31], prev_knot};
    end
    if (cmd.t_init) begin
      t <= cmd.deriv ? sat32(cubic_x3) : c_cubic;
    end else if (cmd.acc) begin
      t <= sat32(sum);
    end
    if (cmd.mul) begin
      prod <= t * p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out_zero || cmd.out_oor || cmd.out_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_zero) begin
      result <= '0;
    end else if (cmd.out_oor) begin
      result.result_value <= '0;
      result.out_of_range <= 1'b1;
      result.segment      <= '0;
    end else if (cmd.out_val) begin
      result.result_value <= t;
      result.out_of_range <= 1'b0;
      result.segment      <= 6'(seg_idx);
    end
  end

  a_offset_nonneg: assert property (@(posedge clk) disable iff (rst)
    cmd.t_init |-> !p[32])
    else $error("segment offset is negative");

endmodule

// ----- rtl/core/cubic_spline_evaluator.sv -----
// ----------------------------------------------------------------------------
// cubic_spline_evaluator: piecewise cubic spline evaluation in Q16.16
// A load or an unused code gives its result beat in the cycle after start.
// A query walks the knot table linearly, one knot read a cycle, so a value
// or slope query on a later segment answers later; a query outside the end
// knots is answered after the range read, an unmatched one after the whole
// walk. One item at a time: busy stays high during a query until the cycle
// that shows the result. The receiver cannot stall. Synchronous reset sets
// knot_count to 3 and idles the controller; the table memories are not
// cleared and must be loaded.
// ----------------------------------------------------------------------------
module cubic_spline_evaluator import cse_pkg::*; #(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  in_t        item,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  output logic       done,
  output out_t       result
);

  localparam int AW = $clog2(MAX_KNOTS);

  // The controller decides every step; the datapath only stores, compares
  // and computes. Status flows back as three compare results.
  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] knot_addr;
  logic [AW-1:0] seg_idx;

  // Controller: knot count register, range check, the walk over the
  // segments in index order (so a query on an inner knot takes the lower
  // segment), and the Horner sequence of three or two multiply-add steps.
  cse_ctrl #(
    .MAX_KNOTS (MAX_KNOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (item.func),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .busy      (busy),
    .cmd       (cmd),
    .knot_addr (knot_addr),
    .seg_idx   (seg_idx)
  );

  // Datapath: the five table memories, one shared 32 by 33 multiplier with
  // a register after it, the saturating adder and the result register, with
  // done marking each result beat for one cycle.
  cse_dp #(
    .MAX_KNOTS (MAX_KNOTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .knot_addr (knot_addr),
    .seg_idx   (seg_idx),
    .sts       (sts),
    .done      (done),
    .result    (result)
  );

endmodule
